FILE: sv/qs3d_pkg.sv
// Shared types and constants for the smallest-three quaternion decoder.
package qs3d_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int RAD_W = 2 * (COMPONENT_BITS - 1);
    localparam int ROOT_W = COMPONENT_BITS - 1;
    localparam int REM_W = COMPONENT_BITS + 2;
    localparam int SQ_W = 2 * COMPONENT_BITS;
    localparam int SUM_W = 2 * COMPONENT_BITS + 2;
    localparam int NUM_CELLS = COMPONENT_BITS - 1;

    localparam longint unsigned SCALE_L = (64'd1 << (COMPONENT_BITS - 1)) - 64'd1;
    localparam logic [COMPONENT_BITS-1:0] SCALE = COMPONENT_BITS'(SCALE_L);
    localparam logic [SUM_W-1:0] FULL_SQ = SUM_W'(SCALE_L * SCALE_L);

    typedef enum logic [1:0] {
        IDX_X = 2'd0,
        IDX_Y = 2'd1,
        IDX_Z = 2'd2,
        IDX_W = 2'd3
    } qs3d_index_t;

    typedef struct packed {
        qs3d_index_t                       largest_index;
        logic                              largest_negative;
        logic signed [COMPONENT_BITS-1:0]  first_small;
        logic signed [COMPONENT_BITS-1:0]  second_small;
        logic signed [COMPONENT_BITS-1:0]  third_small;
    } qs3d_item_t;

    typedef struct packed {
        logic              valid;
        qs3d_item_t        item;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } qs3d_cell_t;

endpackage

FILE: sv/quaternion_smallest_three_decode_core.sv
// Top level of the smallest-three quaternion decoder.
//
// The input channel (s_valid, s_ready and the s_ payload) carries one compressed
// quaternion per transfer: the dropped component's index and sign and the three
// kept components. The result channel (m_valid, m_ready, m_comp_x to m_comp_w)
// returns one full quaternion per input transfer, in the same order.
// The kept components pass straight through; the dropped one is rebuilt as the
// rounded square root of the scale squared less the kept squares.
// An input transfer passes a register for the squares, a register for the
// radicand, one square-root cell per root bit (15 at 16-bit components) and
// a register for rounding and output. Throughput is one item per cycle while
// no result is stalled, set by the chain of root cells, which all move together.
// Reset clears every valid flag, so the block comes up empty and ready.
// When the receiver stalls a waiting result, the whole chain holds and s_ready
// falls in the same cycle; it rises again as soon as the result is taken.
module quaternion_smallest_three_decode_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_largest_index,
    input  logic                                  s_largest_negative,
    input  logic signed [qs3d_pkg::COMPONENT_BITS-1:0] s_first_small,
    input  logic signed [qs3d_pkg::COMPONENT_BITS-1:0] s_second_small,
    input  logic signed [qs3d_pkg::COMPONENT_BITS-1:0] s_third_small,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [qs3d_pkg::COMPONENT_BITS-1:0] m_comp_x,
    output logic signed [qs3d_pkg::COMPONENT_BITS-1:0] m_comp_y,
    output logic signed [qs3d_pkg::COMPONENT_BITS-1:0] m_comp_z,
    output logic signed [qs3d_pkg::COMPONENT_BITS-1:0] m_comp_w
);
    import qs3d_pkg::*;

    logic                              en;
    qs3d_item_t                        in_item;
    qs3d_cell_t                        chain [NUM_CELLS+1];
    qs3d_cell_t                        last;
    logic                              round_up;
    logic [COMPONENT_BITS-1:0]         big;
    logic [COMPONENT_BITS-1:0]         rebuilt;
    logic                              m_valid_reg;
    logic [COMPONENT_BITS-1:0]         x_reg, y_reg, z_reg, w_reg;
    logic [COMPONENT_BITS-1:0]         x_next, y_next, z_next, w_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        in_item.largest_index    = qs3d_index_t'(s_largest_index);
        in_item.largest_negative = s_largest_negative;
        in_item.first_small      = s_first_small;
        in_item.second_small     = s_second_small;
        in_item.third_small      = s_third_small;
    end

    qs3d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_item  (in_item),
        .out_cell (chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        qs3d_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_cell  (chain[i]),
            .out_cell (chain[i+1])
        );
    end

    assign last = chain[NUM_CELLS];

    always_comb begin
        round_up = last.rem > REM_W'(last.root);
        big      = COMPONENT_BITS'(last.root) + COMPONENT_BITS'(round_up);
        rebuilt  = last.item.largest_negative ? (~big + 1'b1) : big;
        x_next   = last.item.first_small;
        y_next   = last.item.second_small;
        z_next   = last.item.third_small;
        w_next   = rebuilt;
        unique case (last.item.largest_index)
            IDX_X: begin
                x_next = rebuilt;
                y_next = last.item.first_small;
                z_next = last.item.second_small;
                w_next = last.item.third_small;
            end
            IDX_Y: begin
                x_next = last.item.first_small;
                y_next = rebuilt;
                z_next = last.item.second_small;
                w_next = last.item.third_small;
            end
            IDX_Z: begin
                x_next = last.item.first_small;
                y_next = last.item.second_small;
                z_next = rebuilt;
                w_next = last.item.third_small;
            end
            IDX_W: begin
                x_next = last.item.first_small;
                y_next = last.item.second_small;
                z_next = last.item.third_small;
                w_next = rebuilt;
            end
            default: begin
                x_next = last.item.first_small;
                y_next = last.item.second_small;
                z_next = last.item.third_small;
                w_next = rebuilt;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            w_reg <= w_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_comp_x = x_reg;
    assign m_comp_y = y_reg;
    assign m_comp_z = z_reg;
    assign m_comp_w = w_reg;

`ifndef SYNTHESIS
    a_last_moves_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (last.valid && en) |=> m_valid)
        else $error("A finished item did not reach the output register.");

    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        last.valid |-> (last.rem <= REM_W'({last.root, 1'b0})))
        else $error("Square-root remainder exceeds twice the root.");

    a_big_in_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        last.valid |-> (big <= SCALE))
        else $error("Rebuilt component exceeds full scale.");

    a_chain_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(last.valid) && $stable(last.root)))
        else $error("Root chain moved while the output was stalled.");
`endif

endmodule

FILE: sv/qs3d_front.sv
// Front end: squares of the kept components, then the clamped radicand.
module qs3d_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  qs3d_pkg::qs3d_item_t   in_item,
    output qs3d_pkg::qs3d_cell_t   out_cell
);
    import qs3d_pkg::*;

    logic              a_valid_reg;
    qs3d_item_t        a_item_reg;
    logic [SQ_W-1:0]   sq0_reg, sq1_reg, sq2_reg;
    logic [SQ_W-1:0]   sq0_next, sq1_next, sq2_next;
    logic [SUM_W-1:0]  sum;
    logic [RAD_W-1:0]  rad;
    qs3d_cell_t        cell_reg;
    qs3d_cell_t        cell_next;

    assign sq0_next = SQ_W'($signed(in_item.first_small) * $signed(in_item.first_small));
    assign sq1_next = SQ_W'($signed(in_item.second_small) * $signed(in_item.second_small));
    assign sq2_next = SQ_W'($signed(in_item.third_small) * $signed(in_item.third_small));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_item_reg <= in_item;
            sq0_reg    <= sq0_next;
            sq1_reg    <= sq1_next;
            sq2_reg    <= sq2_next;
        end
    end

    always_comb begin
        sum = SUM_W'(sq0_reg) + SUM_W'(sq1_reg) + SUM_W'(sq2_reg);
        if (sum >= FULL_SQ) begin
            rad = '0;
        end else begin
            rad = RAD_W'(FULL_SQ - sum);
        end
        cell_next.valid = a_valid_reg;
        cell_next.item  = a_item_reg;
        cell_next.rad   = rad;
        cell_next.rem   = '0;
        cell_next.root  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_cell = cell_reg;

endmodule

FILE: sv/qs3d_sqrt_cell.sv
// One square-root cell: takes two radicand bits and settles one root bit.
module qs3d_sqrt_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  qs3d_pkg::qs3d_cell_t   in_cell,
    output qs3d_pkg::qs3d_cell_t   out_cell
);
    import qs3d_pkg::*;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    qs3d_cell_t       cell_reg;
    qs3d_cell_t       cell_next;

    always_comb begin
        rem_shift = {in_cell.rem[REM_W-3:0], in_cell.rad[RAD_W-1 -: 2]};
        trial     = REM_W'({in_cell.root, 2'b01});
        cell_next       = in_cell;
        cell_next.rad   = {in_cell.rad[RAD_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
            cell_next.rem  = rem_shift - trial;
            cell_next.root = {in_cell.root[ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_shift;
            cell_next.root = {in_cell.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_cell = cell_reg;

endmodule
